// ===== design/five_shot_extreme_spread_trial_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the five-shot extreme spread trial unit
// Each checker reports through $error. The checkers are empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef FIVE_SHOT_EXTREME_SPREAD_TRIAL_UNIT_MACROS_SVH
`define FIVE_SHOT_EXTREME_SPREAD_TRIAL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset
`define FSET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define FSET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FSET_ASSERT(lbl, prop, msg)
`define FSET_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/fset_pkg.sv =====
// ----------------------------------------------------------------------------
// fset_pkg
// Shared constants, tables and types for the extreme spread trial unit.
// ----------------------------------------------------------------------------
package fset_pkg;

    localparam int SHOTS         = 5;
    localparam int GENS          = 2 * SHOTS;
    localparam int GEN_W         = $clog2(GENS);
    localparam int SHOT_W        = $clog2(SHOTS);
    localparam int ROT_W         = $clog2(GENS - SHOTS);
    localparam int FRAC_BITS     = 28;
    localparam int CORDIC_ROUNDS = 28;
    localparam int CW            = 34;  // CORDIC datapath width
    localparam int XW            = 36;  // shot coordinate width

    localparam logic [1:0] ACT_LOAD_PHASE = 2'd0;
    localparam logic [1:0] ACT_LOAD_STEP  = 2'd1;
    localparam logic [1:0] ACT_TRIAL      = 2'd2;

    localparam logic [31:0]          TWO_LN2_Q30 = 32'h58B90BFC;
    localparam logic [31:0]          HALF_PI_Q30 = 32'h6487ED51;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

    // Handshake of an iterative unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_st;

    // Arctangent of 2^-i in Q0.30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            5'd24:   v = 30'h0000003F;
            5'd25:   v = 30'h0000001F;
            5'd26:   v = 30'h0000000F;
            5'd27:   v = 30'h00000008;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/five_shot_extreme_spread_trial_unit.sv =====
// ----------------------------------------------------------------------------
// five_shot_extreme_spread_trial_unit
// Weyl generators feeding a Box-Muller shot model; reports extreme spread.
// ----------------------------------------------------------------------------
// A load transaction gives no result. A trial transaction runs from its
// accepting edge to the edge that loads the output register, and the unit is
// not ready meanwhile; a shot whose u phase is zero finishes sooner than any
// nonzero one, and a result still waiting in the output register holds the
// trial at its last step.
// Each shot with a nonzero u phase runs the logarithm unit (normalize steps,
// 28 squaring rounds and a scaling step) and then the bit-serial square
// root, while the CORDIC unit works on the angle alongside; a zero u phase
// skips both and waits only for the CORDIC. Each shot then runs its multiply
// steps, MULX and MULY, plus a PAIR_A and PAIR_B step for every earlier shot,
// and the trial ends with a square root of the largest squared distance.
// The result waits in an output register until it is taken.
module five_shot_extreme_spread_trial_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_gen_index,
    input  logic [63:0] i_load_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_spread
);

`include "five_shot_extreme_spread_trial_unit_macros.svh"

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_UPD      = 4'd1;
    localparam logic [3:0] ST_SH_START = 4'd2;
    localparam logic [3:0] ST_SH_WAIT  = 4'd3;
    localparam logic [3:0] ST_MULX     = 4'd4;
    localparam logic [3:0] ST_MULY     = 4'd5;
    localparam logic [3:0] ST_PAIR_A   = 4'd6;
    localparam logic [3:0] ST_PAIR_B   = 4'd7;
    localparam logic [3:0] ST_STORE    = 4'd8;
    localparam logic [3:0] ST_ROT      = 4'd9;
    localparam logic [3:0] ST_FIN      = 4'd10;
    localparam logic [3:0] ST_FIN_WAIT = 4'd11;
    localparam logic [3:0] ST_OUT      = 4'd12;

    localparam int GENS  = fset_pkg::GENS;
    localparam int SHOTS = fset_pkg::SHOTS;
    localparam int XW    = fset_pkg::XW;

    logic [3:0]                    r_state, n_state;
    logic [fset_pkg::SHOT_W-1:0]   r_shot;
    logic [fset_pkg::SHOT_W-1:0]   r_j;
    logic [fset_pkg::ROT_W-1:0]    r_rot;
    logic                          r_rdone, r_cdone;
    logic                          r_out_valid;
    logic [31:0]                   r_spread;

    logic [63:0]                   r_ph [GENS];
    logic [63:0]                   r_st [GENS];
    logic signed [XW-1:0]          r_xs [SHOTS];
    logic signed [XW-1:0]          r_ys [SHOTS];
    logic signed [XW-1:0]          r_xn, r_yn;
    logic [31:0]                   r_r;
    logic [63:0]                   r_sqa;
    logic                          r_sata;
    logic [63:0]                   r_best;
    logic [31:0]                   r_res;

    logic                          in_take;
    logic                          out_load;
    logic                          log_start, cor_start, isq_start;
    fset_pkg::t_unit_st            log_st, cor_st, isq_st;
    logic [34:0]                   log_s;
    logic signed [fset_pkg::CW-1:0] cor_cos, cor_sin;
    logic [63:0]                   isq_rad;
    logic [31:0]                   isq_root;

    logic signed [32:0]            mul_a;
    logic signed [XW-1:0]          mul_b;
    logic signed [XW+32:0]         prod;
    logic signed [XW:0]            dif;
    logic [XW:0]                   dmag;
    logic                          big;
    logic [64:0]                   dsum;
    logic [63:0]                   d2;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_take    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // Iterative units
    assign log_start = (r_state == ST_SH_START) && (r_ph[0] != 64'd0);
    assign cor_start = (r_state == ST_SH_START);
    assign isq_start = (r_state == ST_FIN) || ((r_state == ST_SH_WAIT) && log_st.done);
    assign isq_rad   = (r_state == ST_FIN) ? r_best : {1'b0, log_s, 28'd0};

    fset_log u_log (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (log_start),
        .i_phase   (r_ph[0]),
        .o_st      (log_st),
        .o_s       (log_s)
    );

    fset_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cor_start),
        .i_angle   (r_ph[SHOTS][63:32]),
        .o_st      (cor_st),
        .o_cos     (cor_cos),
        .o_sin     (cor_sin)
    );

    fset_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (isq_start),
        .i_radicand (isq_rad),
        .o_st       (isq_st),
        .o_root     (isq_root)
    );

    // Shared multiplier and distance arithmetic
    always_comb begin
        dif = (r_state == ST_PAIR_A) ?
              ({r_xn[XW-1], r_xn} - {r_xs[r_j][XW-1], r_xs[r_j]}) :
              ({r_yn[XW-1], r_yn} - {r_ys[r_j][XW-1], r_ys[r_j]});
        dmag = dif[XW] ? unsigned'(-dif) : unsigned'(dif);
        big  = |dmag[XW:32];
        case (r_state)
            ST_MULX: begin
                mul_a = signed'({1'b0, r_r});
                mul_b = XW'(cor_sin);
            end
            ST_MULY: begin
                mul_a = signed'({1'b0, r_r});
                mul_b = XW'(cor_cos);
            end
            ST_PAIR_A, ST_PAIR_B: begin
                mul_a = signed'({1'b0, dmag[31:0]});
                mul_b = signed'({4'd0, dmag[31:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
        dsum = {1'b0, r_sqa} + {1'b0, prod[63:0]};
        d2   = (r_sata || big || dsum[64]) ? 64'hFFFFFFFFFFFFFFFF : dsum[63:0];
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take && (i_action == fset_pkg::ACT_TRIAL)) n_state = ST_UPD;
            end
            ST_UPD:      n_state = ST_SH_START;
            ST_SH_START: n_state = ST_SH_WAIT;
            ST_SH_WAIT: begin
                if (r_rdone && r_cdone) n_state = ST_MULX;
            end
            ST_MULX:     n_state = ST_MULY;
            ST_MULY:     n_state = (r_shot == '0) ? ST_STORE : ST_PAIR_A;
            ST_PAIR_A:   n_state = ST_PAIR_B;
            ST_PAIR_B: begin
                n_state = (r_j == r_shot - 1'b1) ? ST_STORE : ST_PAIR_A;
            end
            ST_STORE: begin
                n_state = (r_shot == fset_pkg::SHOT_W'(SHOTS - 1)) ? ST_ROT : ST_SH_START;
            end
            ST_ROT: begin
                if (r_rot == fset_pkg::ROT_W'(GENS - SHOTS - 1)) n_state = ST_FIN;
            end
            ST_FIN:      n_state = ST_FIN_WAIT;
            ST_FIN_WAIT: begin
                if (isq_st.done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rdone     <= 1'b0;
            r_cdone     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_SH_START) begin
                r_rdone <= (r_ph[0] == 64'd0);
                r_cdone <= 1'b0;
            end else begin
                if ((r_state == ST_SH_WAIT) && isq_st.done) r_rdone <= 1'b1;
                if (cor_st.done) r_cdone <= 1'b1;
            end
        end
    end

    // Generator phases: load, advance, rotate one place per shot and per ST_ROT step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < GENS; k++) r_ph[k] <= 64'd0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_take && (i_action == fset_pkg::ACT_LOAD_PHASE) &&
                        ({1'b0, i_gen_index} < 5'(GENS))) begin
                        r_ph[i_gen_index[fset_pkg::GEN_W-1:0]] <= i_load_value;
                    end
                end
                ST_UPD: begin
                    for (int k = 0; k < GENS; k++) r_ph[k] <= r_ph[k] + r_st[k];
                end
                ST_STORE, ST_ROT: begin
                    for (int k = 0; k < GENS; k++) r_ph[k] <= r_ph[(k + 1) % GENS];
                end
                default: ;
            endcase
        end
    end

    // Step words follow the same rotation
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_take && (i_action == fset_pkg::ACT_LOAD_STEP) &&
                    ({1'b0, i_gen_index} < 5'(GENS))) begin
                    r_st[i_gen_index[fset_pkg::GEN_W-1:0]] <= i_load_value;
                end
            end
            ST_STORE, ST_ROT: begin
                for (int k = 0; k < GENS; k++) r_st[k] <= r_st[(k + 1) % GENS];
            end
            default: ;
        endcase
    end

    // Shot datapath and counters
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_UPD: begin
                r_shot <= '0;
                r_best <= 64'd0;
            end
            ST_SH_START: begin
                if (r_ph[0] == 64'd0) r_r <= 32'hFFFFFFFF;
            end
            ST_SH_WAIT: begin
                if (isq_st.done) r_r <= isq_root;
            end
            ST_MULX: r_xn <= prod[XW+30:31];
            ST_MULY: begin
                r_yn <= prod[XW+30:31];
                r_j  <= '0;
            end
            ST_PAIR_A: begin
                r_sqa  <= prod[63:0];
                r_sata <= big;
            end
            ST_PAIR_B: begin
                if (d2 > r_best) r_best <= d2;
                r_j <= r_j + 1'b1;
            end
            ST_STORE: begin
                r_xs[r_shot] <= r_xn;
                r_ys[r_shot] <= r_yn;
                r_shot       <= r_shot + 1'b1;
                r_rot        <= '0;
            end
            ST_ROT: r_rot <= r_rot + 1'b1;
            ST_FIN_WAIT: begin
                if (isq_st.done) r_res <= isq_root;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) r_spread <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_spread    = r_spread;

    `FSET_ASSERT(a_trial_starts, in_take && (i_action == fset_pkg::ACT_TRIAL) |=> r_state == ST_UPD, "trial transaction did not start the sequencer")
    `FSET_ASSERT(a_shot_range, r_shot <= fset_pkg::SHOT_W'(SHOTS - 1) || r_state != ST_SH_START, "shot counter out of range")
    `FSET_ASSERT(a_out_from_seq, $rose(r_out_valid) |-> $past(r_state) == ST_OUT, "result shown without a finished trial")
    `FSET_ASSERT(a_idle_units, r_state == ST_IDLE |-> !log_st.busy && !cor_st.busy && !isq_st.busy, "unit busy while idle")

endmodule

// ===== design/fset_isqrt.sv =====
// ----------------------------------------------------------------------------
// fset_isqrt
// Bit-serial integer square root of a 64-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
module fset_isqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [63:0]      i_radicand,
    output fset_pkg::t_unit_st o_st,
    output logic [31:0]      o_root
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_idx;
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] bitv;
    logic [63:0] trial;

    // Form the trial subtrahend for this digit
    assign bitv  = 64'd1 << {r_idx, 1'b0};
    assign trial = r_res + bitv;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_idx == 5'd0)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Advance one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_radicand;
            r_res <= 64'd0;
            r_idx <= 5'd31;
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + bitv;
            end else begin
                r_res <= r_res >> 1;
            end
            r_idx <= r_idx - 5'd1;
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_root    = r_res[31:0];

endmodule

// ===== design/fset_log.sv =====
// ----------------------------------------------------------------------------
// fset_log
// Computes s = -2 ln(p / 2^64) in Q7.28 by normalizing and repeated squaring.
// ----------------------------------------------------------------------------
module fset_log (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [63:0]      i_phase,
    output fset_pkg::t_unit_st o_st,
    output logic [34:0]      o_s
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQR  = 2'd2;
    localparam logic [1:0] L_FIN  = 2'd3;

    localparam logic [31:0] TWO_LN2 = fset_pkg::TWO_LN2_Q30;

    logic [1:0]  r_state, n_state;
    logic        r_done, n_done;
    logic [4:0]  r_k;
    logic [63:0] r_p;
    logic [5:0]  r_e;
    logic [31:0] r_m;
    logic [27:0] r_frac;
    logic [34:0] r_s;

    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [34:0] len;
    logic [63:0] lo_prod;
    logic [34:0] hi_prod;
    logic [36:0] s_sum;

    // Square the mantissa and scale the length by 2 ln 2
    always_comb begin
        sq      = {32'd0, r_m} * {32'd0, r_m};
        sq_sh   = sq[63:31];
        len     = 35'h400000000 - {1'b0, r_e, r_frac};
        lo_prod = {32'd0, len[31:0]} * {32'd0, TWO_LN2};
        hi_prod = {32'd0, len[34:32]} * {3'd0, TWO_LN2};
        s_sum   = {hi_prod, 2'b00} + {3'd0, lo_prod[63:30]};
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) n_state = L_NORM;
            end
            L_NORM: begin
                if (r_p[63]) n_state = L_SQR;
            end
            L_SQR: begin
                if (r_k == 5'(fset_pkg::FRAC_BITS - 1)) n_state = L_FIN;
            end
            L_FIN: begin
                n_state = L_IDLE;
                n_done  = 1'b1;
            end
            default: n_state = L_IDLE;
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath: normalize, square, then scale
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_p <= i_phase;
                    r_e <= 6'd63;
                end
            end
            L_NORM: begin
                if (r_p[63]) begin
                    r_m    <= r_p[63:32];
                    r_k    <= 5'd0;
                    r_frac <= '0;
                end else if (r_p[63:56] == 8'd0) begin
                    r_p <= r_p << 8;
                    r_e <= r_e - 6'd8;
                end else begin
                    r_p <= r_p << 1;
                    r_e <= r_e - 6'd1;
                end
            end
            L_SQR: begin
                r_frac <= {r_frac[26:0], sq_sh[32]};
                r_m    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
                r_k    <= r_k + 5'd1;
            end
            L_FIN: begin
                r_s <= s_sum[34:0];
            end
            default: ;
        endcase
    end

    assign o_st.busy = (r_state != L_IDLE);
    assign o_st.done = r_done;
    assign o_s       = r_s;

endmodule

// ===== design/fset_cordic.sv =====
// ----------------------------------------------------------------------------
// fset_cordic
// Rotation-mode CORDIC giving cos and sin of 2*pi*a/2^32 in Q4.30.
// ----------------------------------------------------------------------------
module fset_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [31:0]                    i_angle,
    output fset_pkg::t_unit_st             o_st,
    output logic signed [fset_pkg::CW-1:0] o_cos,
    output logic signed [fset_pkg::CW-1:0] o_sin
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_PREP = 2'd1;
    localparam logic [1:0] C_ROT  = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic                          r_done, n_done;
    logic [4:0]                    r_i;
    logic [1:0]                    r_q;
    logic [29:0]                   r_a;
    logic signed [fset_pkg::CW-1:0] r_x, r_y, r_z;

    logic [61:0]                   zp;
    logic signed [fset_pkg::CW-1:0] xs, ys, at;

    // Scale the angle and form the shifted terms
    always_comb begin
        zp = {32'd0, r_a} * {30'd0, fset_pkg::HALF_PI_Q30};
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = signed'({4'd0, fset_pkg::atan_q30(r_i)});
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = C_PREP;
            C_PREP: n_state = C_ROT;
            C_ROT: begin
                if (r_i == 5'(fset_pkg::CORDIC_ROUNDS - 1)) begin
                    n_state = C_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Rotate one round per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_a <= i_angle[29:0];
                    r_q <= i_angle[31:30];
                end
            end
            C_PREP: begin
                r_z <= signed'({2'b00, zp[61:30]});
                r_x <= fset_pkg::CORDIC_GAIN;
                r_y <= '0;
                r_i <= 5'd0;
            end
            C_ROT: begin
                if (!r_z[fset_pkg::CW-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 5'd1;
            end
            default: ;
        endcase
    end

    // Map the result back to its quadrant
    always_comb begin
        case (r_q)
            2'd0: begin o_cos = r_x;  o_sin = r_y;  end
            2'd1: begin o_cos = -r_y; o_sin = r_x;  end
            2'd2: begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y; o_sin = -r_x; end
        endcase
    end

    assign o_st.busy = (r_state != C_IDLE);
    assign o_st.done = r_done;

endmodule
